// ===== rtl/tclp_pkg.sv =====
package tclp_pkg;

   // Line buffer size; one slot is kept free, as in the original firmware.
   localparam int LINE_BYTES  = 16;
   localparam int STORE_DEPTH = LINE_BYTES - 1;
   localparam int CNT_W       = $clog2(LINE_BYTES);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam logic [7:0] CH_LF      = 8'd10;
   localparam logic [7:0] CH_CR      = 8'd13;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_MINUS   = 8'd45;
   localparam logic [7:0] CH_ZERO    = 8'd48;
   localparam logic [7:0] CH_NINE    = 8'd57;
   localparam logic [7:0] CH_QUERY   = 8'd63;
   localparam logic [7:0] CH_LOWER_A = 8'd97;
   localparam logic [7:0] CH_LOWER_Z = 8'd122;
   localparam logic [7:0] CASE_SHIFT = 8'd32;

   localparam logic [7:0] CMD_PROP   = 8'd80;  // 'P'
   localparam logic [7:0] CMD_INTEG  = 8'd73;  // 'I'
   localparam logic [7:0] CMD_DERIV  = 8'd68;  // 'D'
   localparam logic [7:0] CMD_SETPT  = 8'd83;  // 'S'
   localparam logic [7:0] CMD_LEFT   = 8'd76;  // 'L'
   localparam logic [7:0] CMD_RIGHT  = 8'd82;  // 'R'
   localparam logic [7:0] CMD_TEST   = 8'd84;  // 'T'

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic step;
      logic apply;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_lf;
      logic line_empty;
      logic scan_done;
      logic slot_free;
   } dp_status_type;

endpackage

// ===== rtl/tclp_ram.sv =====
module tclp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Addresses past the end read as zero.
      if (32'(rd_addr) < DEPTH) begin
         rd_data_ff <= mem_ff[rd_addr];
      end else begin
         rd_data_ff <= '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tclp_ctrl.sv =====
module tclp_ctrl
   import tclp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (status.is_lf && !status.line_empty) ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/tclp_dp.sv =====
module tclp_dp
   import tclp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_gain_p,
   output logic signed [15:0] rsp_gain_i,
   output logic signed [15:0] rsp_gain_d,
   output logic signed [15:0] rsp_target_angle,
   output logic signed [15:0] rsp_dead_left,
   output logic signed [15:0] rsp_dead_right,
   output logic signed [15:0] rsp_test_duty,
   output logic               rsp_report_request,
   output logic               rsp_deadband_changed,
   output logic               rsp_line_end
);

   // Line buffer state.
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [7:0]       cmd_char_ff, cmd_char_in;

   // Scan state.
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [15:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic             digits_ff, digits_in;

   // Tuning registers.
   logic [15:0] prop_ff, prop_in;
   logic [15:0] integ_ff, integ_in;
   logic [15:0] deriv_ff, deriv_in;
   logic [15:0] setpt_ff, setpt_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] right_ff, right_in;
   logic [15:0] test_ff, test_in;

   // Per-request flags.
   logic report_ff, report_in;
   logic dead_ff, dead_in;
   logic lend_ff, lend_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic [15:0] o_prop_ff, o_integ_ff, o_deriv_ff, o_setpt_ff;
   logic [15:0] o_left_ff, o_right_ff, o_test_ff;
   logic        o_report_ff, o_dead_ff, o_lend_ff;

   logic        wr_en;
   logic [7:0]  rd_byte;
   logic        in_range, is_digit, take_space, take_minus, advance;
   logic [15:0] value, value_x10, digit;
   logic [7:0]  cmd_up;

   tclp_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff[ADDR_W-1:0]),
      .wr_data(req_rx_byte),
      .rd_addr(pos_in[ADDR_W-1:0]),
      .rd_data(rd_byte)
   );

   // The read address follows the next scan position, so the byte at the
   // current position is ready in each scan cycle.
   assign wr_en = cmd.accept && (req_rx_byte != CH_LF) && (req_rx_byte != CH_CR)
                  && (32'(fill_ff) < STORE_DEPTH);

   assign in_range   = pos_ff < fill_ff;
   assign is_digit   = (rd_byte >= CH_ZERO) && (rd_byte <= CH_NINE);
   assign take_space = !digits_ff && (rd_byte == CH_SPACE);
   assign take_minus = !digits_ff && (rd_byte == CH_MINUS);
   assign advance    = in_range && (take_space || take_minus || is_digit);
   assign digit      = {8'd0, rd_byte - CH_ZERO};

   assign value     = neg_ff ? (16'd0 - acc_ff) : acc_ff;
   assign value_x10 = (value << 3) + (value << 1);
   assign cmd_up    = ((cmd_char_ff >= CH_LOWER_A) && (cmd_char_ff <= CH_LOWER_Z))
                      ? (cmd_char_ff - CASE_SHIFT) : cmd_char_ff;

   always_comb begin
      status.is_lf      = (req_rx_byte == CH_LF);
      status.line_empty = (fill_ff == '0);
      status.scan_done  = !advance;
      status.slot_free  = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      fill_in     = fill_ff;
      cmd_char_in = cmd_char_ff;
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      digits_in   = digits_ff;
      prop_in     = prop_ff;
      integ_in    = integ_ff;
      deriv_in    = deriv_ff;
      setpt_in    = setpt_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      test_in     = test_ff;
      report_in   = report_ff;
      dead_in     = dead_ff;
      lend_in     = lend_ff;

      if (cmd.accept) begin
         pos_in    = CNT_W'(1);
         acc_in    = '0;
         neg_in    = 1'b0;
         digits_in = 1'b0;
         report_in = 1'b0;
         dead_in   = 1'b0;
         lend_in   = (req_rx_byte == CH_LF);
         if (wr_en) begin
            fill_in = fill_ff + CNT_W'(1);
            if (fill_ff == '0) begin
               cmd_char_in = req_rx_byte;
            end
         end
      end

      if (cmd.step && advance) begin
         pos_in = pos_ff + CNT_W'(1);
         if (take_minus) begin
            neg_in    = 1'b1;
            digits_in = 1'b1;
         end else if (is_digit) begin
            acc_in    = (acc_ff << 3) + (acc_ff << 1) + digit;
            digits_in = 1'b1;
         end
      end

      if (cmd.apply) begin
         fill_in = '0;
         unique case (cmd_up)
            CMD_PROP:  prop_in  = value;
            CMD_INTEG: integ_in = value;
            CMD_DERIV: deriv_in = value;
            CMD_SETPT: setpt_in = value_x10;
            CMD_LEFT: begin
               left_in = value;
               dead_in = 1'b1;
            end
            CMD_RIGHT: begin
               right_in = value;
               dead_in  = 1'b1;
            end
            CMD_TEST:  test_in   = value;
            CH_QUERY:  report_in = 1'b1;
            default: begin
               report_in = report_ff;
            end
         endcase
      end

      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         prop_ff      <= '0;
         integ_ff     <= '0;
         deriv_ff     <= '0;
         setpt_ff     <= '0;
         left_ff      <= '0;
         right_ff     <= '0;
         test_ff      <= '0;
         report_ff    <= 1'b0;
         dead_ff      <= 1'b0;
         lend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         prop_ff      <= prop_in;
         integ_ff     <= integ_in;
         deriv_ff     <= deriv_in;
         setpt_ff     <= setpt_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         test_ff      <= test_in;
         report_ff    <= report_in;
         dead_ff      <= dead_in;
         lend_ff      <= lend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_char_ff <= cmd_char_in;
      pos_ff      <= pos_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      digits_ff   <= digits_in;
      if (cmd.emit) begin
         o_prop_ff   <= prop_ff;
         o_integ_ff  <= integ_ff;
         o_deriv_ff  <= deriv_ff;
         o_setpt_ff  <= setpt_ff;
         o_left_ff   <= left_ff;
         o_right_ff  <= right_ff;
         o_test_ff   <= test_ff;
         o_report_ff <= report_ff;
         o_dead_ff   <= dead_ff;
         o_lend_ff   <= lend_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_gain_p           = $signed(o_prop_ff);
   assign rsp_gain_i           = $signed(o_integ_ff);
   assign rsp_gain_d           = $signed(o_deriv_ff);
   assign rsp_target_angle     = $signed(o_setpt_ff);
   assign rsp_dead_left        = $signed(o_left_ff);
   assign rsp_dead_right       = $signed(o_right_ff);
   assign rsp_test_duty        = $signed(o_test_ff);
   assign rsp_report_request   = o_report_ff;
   assign rsp_deadband_changed = o_dead_ff;
   assign rsp_line_end         = o_lend_ff;

endmodule

// ===== rtl/tuning_command_line_parser.sv =====
// Channel    Direction  Handshake             Payload
// request    in         req_valid/req_stall   req_rx_byte
// response   out        rsp_valid/rsp_stall   rsp_gain_p .. rsp_line_end
//
// An ordinary byte (or a carriage return, or an empty line feed) skips the scan.
// A line feed that ends a stored line (up to 15 bytes) is scanned and applied;
// the scan reads one stored byte per cycle from the line RAM port.
// Reset is synchronous and clears the fill count, the tuning registers and the flags.
// The response register holds a finished response while rsp_stall is high; the next
// request is still accepted and processed, and waits only to load its own response.
module tuning_command_line_parser
   import tclp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_gain_p,
   output logic signed [15:0] rsp_gain_i,
   output logic signed [15:0] rsp_gain_d,
   output logic signed [15:0] rsp_target_angle,
   output logic signed [15:0] rsp_dead_left,
   output logic signed [15:0] rsp_dead_right,
   output logic signed [15:0] rsp_test_duty,
   output logic               rsp_report_request,
   output logic               rsp_deadband_changed,
   output logic               rsp_line_end
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller sequences each request: accept, an optional scan of the stored
   // line followed by applying the command, and loading the response register.
   tclp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds the line RAM, the number accumulator, the tuning
   // registers and the response register.
   tclp_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_rx_byte         (req_rx_byte),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_gain_p          (rsp_gain_p),
      .rsp_gain_i          (rsp_gain_i),
      .rsp_gain_d          (rsp_gain_d),
      .rsp_target_angle    (rsp_target_angle),
      .rsp_dead_left       (rsp_dead_left),
      .rsp_dead_right      (rsp_dead_right),
      .rsp_test_duty       (rsp_test_duty),
      .rsp_report_request  (rsp_report_request),
      .rsp_deadband_changed(rsp_deadband_changed),
      .rsp_line_end        (rsp_line_end)
   );

endmodule

// ===== dv/tb.sv =====
module tb
   import tclp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // One expected response: the tuning registers after a byte, plus the three flags.
   typedef struct packed {
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic signed [15:0] target_angle;
      logic signed [15:0] dead_left;
      logic signed [15:0] dead_right;
      logic signed [15:0] test_duty;
      logic               report_request;
      logic               deadband_changed;
      logic               line_end;
   } tune_resp_type;

   // Every input starts at a known value, before the first clock edge.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic [7:0] req_rx_byte = 8'd0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [15:0] rsp_gain_p;
   logic signed [15:0] rsp_gain_i;
   logic signed [15:0] rsp_gain_d;
   logic signed [15:0] rsp_target_angle;
   logic signed [15:0] rsp_dead_left;
   logic signed [15:0] rsp_dead_right;
   logic signed [15:0] rsp_test_duty;
   logic rsp_report_request;
   logic rsp_deadband_changed;
   logic rsp_line_end;

   tuning_command_line_parser u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_gain_p           (rsp_gain_p),
      .rsp_gain_i           (rsp_gain_i),
      .rsp_gain_d           (rsp_gain_d),
      .rsp_target_angle     (rsp_target_angle),
      .rsp_dead_left        (rsp_dead_left),
      .rsp_dead_right       (rsp_dead_right),
      .rsp_test_duty        (rsp_test_duty),
      .rsp_report_request   (rsp_report_request),
      .rsp_deadband_changed (rsp_deadband_changed),
      .rsp_line_end         (rsp_line_end)
   );

   always #4 clock = ~clock;

   // Bytes waiting to be offered, and responses predicted for accepted requests.
   logic [7:0] pending_bytes[$];
   tune_resp_type expected_resp[$];

   // Shadow copy of the parser: line buffer, fill count and tuning registers.
   logic [7:0]  line_mem [0:STORE_DEPTH-1];
   int unsigned line_fill = 0;
   logic [15:0] kp_q = '0;
   logic [15:0] ki_q = '0;
   logic [15:0] kd_q = '0;
   logic [15:0] setpt_q = '0;
   logic [15:0] dl_q = '0;
   logic [15:0] dr_q = '0;
   logic [15:0] tduty_q = '0;

   // Phase controls. They are only changed on the falling edge, so the clocked
   // processes never race with them.
   bit calm_send = 1'b0;
   bit calm_recv = 1'b0;
   bit hold_trigger = 1'b0;

   int errors = 0;
   int bytes_queued = 0;
   int bytes_sent = 0;
   int resp_checked = 0;
   int lines_ended = 0;
   int reports_seen = 0;
   int deadband_seen = 0;

   // Applies one received byte to the shadow state and returns the response that
   // the block must produce for it.
   function automatic tune_resp_type predict_byte(input logic [7:0] c);
      tune_resp_type r;
      logic [7:0]  cmd;
      logic [15:0] v;
      logic [31:0] acc;
      int unsigned pos;
      bit          neg;
      r = '0;
      if (c == CH_LF) begin
         r.line_end = 1'b1;
         if (line_fill != 0) begin
            // Number after the letter: spaces, an optional minus, then digits.
            // The first byte that breaks that pattern ends the scan.
            pos = 1;
            acc = '0;
            neg = 1'b0;
            while (pos < line_fill && line_mem[pos] == CH_SPACE)
               pos++;
            if (pos < line_fill && line_mem[pos] == CH_MINUS) begin
               neg = 1'b1;
               pos++;
            end
            while (pos < line_fill && line_mem[pos] >= CH_ZERO && line_mem[pos] <= CH_NINE) begin
               acc = acc * 32'd10 + 32'(line_mem[pos] - CH_ZERO);
               pos++;
            end
            if (neg)
               acc = -acc;
            v = acc[15:0];
            cmd = line_mem[0];
            if (cmd >= CH_LOWER_A && cmd <= CH_LOWER_Z)
               cmd = cmd - CASE_SHIFT;
            case (cmd)
               CMD_PROP:  kp_q = v;
               CMD_INTEG: ki_q = v;
               CMD_DERIV: kd_q = v;
               // The setpoint is stored in hundredths, so the value is scaled
               // by ten and wraps at 16 bits.
               CMD_SETPT: setpt_q = v * 16'd10;
               CMD_LEFT: begin
                  dl_q = v;
                  r.deadband_changed = 1'b1;
               end
               CMD_RIGHT: begin
                  dr_q = v;
                  r.deadband_changed = 1'b1;
               end
               CMD_TEST:  tduty_q = v;
               CH_QUERY:  r.report_request = 1'b1;
               default: ;
            endcase
         end
         line_fill = 0;
      end else if (c != CH_CR) begin
         // Bytes past the end of the buffer are simply dropped.
         if (line_fill < STORE_DEPTH) begin
            line_mem[line_fill] = c;
            line_fill++;
         end
      end
      r.gain_p       = kp_q;
      r.gain_i       = ki_q;
      r.gain_d       = kd_q;
      r.target_angle = setpt_q;
      r.dead_left    = dl_q;
      r.dead_right   = dr_q;
      r.test_duty    = tduty_q;
      return r;
   endfunction

   // Idle cycles before the next request or after a response. At least a third of the
   // draws are zero so back-to-back traffic is common even in noisy phases.
   function automatic int unsigned draw_wait(input bit calm);
      if (calm || $urandom_range(0, 2) == 0)
         return 0;
      return $urandom_range(0, 12);
   endfunction

   task automatic log_mismatch(input string msg);
      if (errors < 40)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         log_mismatch($sformatf("response %0d %s got %h expected %h",
                                resp_checked, name, got, want));
   endtask

   // Driver. A request stays up, unchanged, until it is taken; then the drawn
   // gap is spent with valid low before the next byte goes out. With no gap the
   // next byte is loaded in the same edge, so valid gets a single assignment.
   int unsigned send_gap = 0;
   always @(posedge clock) begin : driver
      bit fire;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         fire = req_valid && !req_stall;
         if (fire) begin
            expected_resp.push_back(predict_byte(req_rx_byte));
            bytes_sent++;
         end
         if (req_valid && !fire) begin
            // Held: payload and valid stay as they are.
         end else if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            send_gap    <= draw_wait(calm_send);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted on its own. While it runs the block keeps
   // taking bytes until its internal buffering is full and it stalls its input.
   int unsigned hold_left = 0;
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_trigger)
         hold_left <= 300;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // Monitor. Each taken response is compared field by field with the oldest
   // prediction, then a random stall is drawn for the following cycles.
   logic rand_stall_q = 1'b0;
   int unsigned stall_left = 0;
   assign rsp_stall = rand_stall_q || (hold_left != 0);

   always @(posedge clock) begin : monitor
      tune_resp_type want;
      int unsigned n;
      if (reset) begin
         rand_stall_q <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_resp.size() == 0) begin
               log_mismatch("response arrived with no request outstanding");
            end else begin
               want = expected_resp.pop_front();
               check_field("gain_p", rsp_gain_p, want.gain_p);
               check_field("gain_i", rsp_gain_i, want.gain_i);
               check_field("gain_d", rsp_gain_d, want.gain_d);
               check_field("target_angle", rsp_target_angle, want.target_angle);
               check_field("dead_left", rsp_dead_left, want.dead_left);
               check_field("dead_right", rsp_dead_right, want.dead_right);
               check_field("test_duty", rsp_test_duty, want.test_duty);
               check_field("report_request", 16'(rsp_report_request),
                           16'(want.report_request));
               check_field("deadband_changed", 16'(rsp_deadband_changed),
                           16'(want.deadband_changed));
               check_field("line_end", 16'(rsp_line_end), 16'(want.line_end));
               if (want.line_end)         lines_ended++;
               if (want.report_request)   reports_seen++;
               if (want.deadband_changed) deadband_seen++;
            end
            resp_checked++;
            n = draw_wait(calm_recv);
            stall_left   <= n;
            rand_stall_q <= (n != 0);
         end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
         end else begin
            stall_left   <= 0;
            rand_stall_q <= 1'b0;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   // One random line. Most are well formed commands with random content; the rest
   // are overlong lines, raw noise, broken number patterns and empty lines.
   task automatic make_line();
      string      cmds;
      int         kind;
      logic [7:0] letter;
      cmds = "PIDSLRT?";
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0)
         letter = 8'($urandom_range(0, 255));
      else
         letter = cmds[$urandom_range(0, 7)];
      if (letter >= "A" && letter <= "Z" && $urandom_range(0, 1) == 1)
         letter = letter + CASE_SHIFT;
      if (kind < 70) begin
         push_byte(letter);
         repeat ($urandom_range(0, 2)) push_byte(CH_SPACE);
         if ($urandom_range(0, 1) == 1)
            push_byte(CH_MINUS);
         // Up to twelve digits, enough to wrap the 32-bit accumulator.
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(6, 12) : $urandom_range(0, 5))
            push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 3) == 0)
            push_byte(CH_CR);
      end else if (kind < 80) begin
         // Longer than the buffer: the tail must be dropped.
         push_byte(letter);
         repeat ($urandom_range(15, 22))
            push_byte($urandom_range(0, 5) == 0 ? CH_SPACE : CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (kind < 92) begin
         repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
      end else if (kind < 97) begin
         // The number is cut short by an unexpected byte.
         push_byte(letter);
         push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
         push_byte($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(0, 255)));
         push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      end else if (kind < 99) begin
         push_byte(CH_CR);
      end
      push_byte(CH_LF);
   endtask

   // Waits on the falling edge until the sender has nothing left and every
   // predicted response has been taken.
   task automatic wait_drain();
      do
         @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_resp.size() != 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lines: a letter with no digits, an empty line, lower case with a
      // minus sign and a carriage return, the report query, a zero byte that stops
      // the number, an unknown letter, the full-scale extremes and a setpoint that
      // wraps when scaled.
      push_text("P\n");
      push_text("\n");
      push_text("i-9\r\n");
      push_text("?\n");
      push_text("L");
      push_byte(8'd0);
      push_text("5\n");
      push_text("x\n");
      push_text("D65535\n");
      push_text("r-32768\n");
      push_text("T7\n");
      push_text("S3277\n");
      wait_drain();

      // Sender runs flat out while the receiver holds off for a long stretch, so
      // the block backs up and stalls its input.
      calm_send    = 1'b1;
      hold_trigger = 1'b1;
      @(negedge clock);
      hold_trigger = 1'b0;
      while (bytes_queued < 330)
         make_line();
      // The sender pauses here until every response is back.
      wait_drain();

      // Both sides idle at random.
      calm_send = 1'b0;
      while (bytes_queued < 780)
         make_line();
      wait_drain();

      // A stretch with no idling on either side.
      calm_send = 1'b1;
      calm_recv = 1'b1;
      while (bytes_queued < 950)
         make_line();
      wait_drain();

      // Let any stray response show up before the verdict.
      repeat (40) @(posedge clock);
      $display("Sent %0d bytes, checked %0d responses over %0d line ends.",
               bytes_sent, resp_checked, lines_ended);
      $display("Saw %0d report queries and %0d deadband updates; %0d mismatches.",
               reports_seen, deadband_seen, errors);
      if (errors == 0 && expected_resp.size() == 0)
         $display("tuning_command_line_parser test passed");
      else
         $display("tuning_command_line_parser test failed");
      $finish;
   end

   // Watchdog, several times the slowest correct run.
   initial begin
      #3_000_000;
      $display("Timeout with %0d responses still expected.", expected_resp.size());
      $display("tuning_command_line_parser test failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tclp_pkg.sv
rtl/tclp_ram.sv
rtl/tclp_ctrl.sv
rtl/tclp_dp.sv
rtl/tuning_command_line_parser.sv
dv/tb.sv
